// ----- hw/rtl/cdcr_pkg.sv -----
// ----------------------------------------------------------------------------
// cdcr_pkg
// Shared types, register codes and bit constants of the cartridge disk
// controller register file and word sequencer.
// ----------------------------------------------------------------------------
package cdcr_pkg;

  localparam int SECTOR_WORDS_DEF  = 256;
  localparam int DRIVE_COUNT_DEF   = 8;
  localparam int LAST_CYLINDER_DEF = 202;

  localparam int SECTORS_PER_TRACK = 12;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  localparam logic [2:0] REG_DS = 3'd0;
  localparam logic [2:0] REG_ER = 3'd1;
  localparam logic [2:0] REG_CS = 3'd2;
  localparam logic [2:0] REG_WC = 3'd3;
  localparam logic [2:0] REG_BA = 3'd4;
  localparam logic [2:0] REG_DA = 3'd5;

  localparam logic [2:0] FN_CTRL_RESET = 3'd0;
  localparam logic [2:0] FN_WRITE      = 3'd1;
  localparam logic [2:0] FN_READ       = 3'd2;

  localparam logic [15:0] CS_WRITABLE = 16'o017517;
  localparam logic [15:0] CS_RESET    = 16'o000200;
  localparam logic [15:0] DS_RESET    = 16'o004300;
  localparam int          CS_GO_BIT    = 0;
  localparam int          CS_IE_BIT    = 6;
  localparam int          CS_READY_BIT = 7;
  localparam int          DS_READY_BIT = 6;

  localparam logic [15:0] ER_NXS = 16'o000040;
  localparam logic [15:0] ER_NXC = 16'o000100;
  localparam logic [15:0] ER_NXD = 16'o000200;
  localparam logic [15:0] ER_OVR = 16'o040000;

  localparam logic [3:0] LAST_SECTOR = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ----- hw/rtl/cdcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdcr_ctrl
// Sequencer: captures an item, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module cdcr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output cdcr_pkg::cmd_t cmd,
  output logic           out_valid
);

  cdcr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdcr_pkg::ST_IDLE: begin
        if (start) state_nxt = cdcr_pkg::ST_EXEC;
      end
      cdcr_pkg::ST_EXEC: begin
        state_nxt = cdcr_pkg::ST_IDLE;
      end
      default: state_nxt = cdcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdcr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == cdcr_pkg::ST_EXEC);
    end
  end

  assign busy        = (state_r == cdcr_pkg::ST_EXEC);
  assign cmd.capture = start && (state_r == cdcr_pkg::ST_IDLE);
  assign cmd.execute = (state_r == cdcr_pkg::ST_EXEC);
  assign out_valid   = out_valid_r;

endmodule

// ----- hw/rtl/cdcr_dp.sv -----
// ----------------------------------------------------------------------------
// cdcr_dp
// Register file, address checks and word sequencer datapath.
// ----------------------------------------------------------------------------
module cdcr_dp #(
  parameter int SECTOR_WORDS  = cdcr_pkg::SECTOR_WORDS_DEF,
  parameter int DRIVE_COUNT   = cdcr_pkg::DRIVE_COUNT_DEF,
  parameter int LAST_CYLINDER = cdcr_pkg::LAST_CYLINDER_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cdcr_pkg::cmd_t cmd,
  input  logic [1:0]     in_action,
  input  logic [2:0]     in_reg_index,
  input  logic [15:0]    in_write_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  output logic [15:0]    out_read_data,
  output logic           out_xfer_valid,
  output logic           out_xfer_to_memory,
  output logic [17:0]    out_bus_address,
  output logic [2:0]     out_disk_unit,
  output logic [20:0]    out_disk_word_index,
  output logic           out_interrupt_request,
  output logic           out_controller_ready
);

  // captured item
  cdcr_pkg::action_t act_r;
  logic [2:0]        idx_r;
  logic [15:0]       wdata_r;

  // architectural state
  logic [7:0]  mask_r;
  logic [15:0] cs_r, cs_nxt;
  logic [15:0] ds_r, ds_nxt;
  logic [15:0] er_r, er_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [17:0] ma_r, ma_nxt;
  logic [2:0]  unit_r, unit_nxt;
  logic [7:0]  cyl_r, cyl_nxt;
  logic        surf_r, surf_nxt;
  logic [3:0]  sec_r, sec_nxt;
  logic [8:0]  wd_r, wd_nxt;

  // result registers
  logic [15:0] rd_r, rd_nxt;
  logic        xv_r, xv_nxt;
  logic        tomem_r, tomem_nxt;
  logic [17:0] ba_r, ba_nxt;
  logic [2:0]  du_r, du_nxt;
  logic [20:0] dwi_r, dwi_nxt;
  logic        irq_r, irq_nxt;
  logic        rdy_r;

  logic [2:0]  fn;
  logic [15:0] cs_wr;
  logic        do_adv;
  logic        do_finish;
  logic [12:0] blk;
  logic [20:0] dwi_calc;

  assign blk = 13'({cyl_r, 4'b0000}) + 13'({cyl_r, 3'b000})
             + (surf_r ? 13'(cdcr_pkg::SECTORS_PER_TRACK) : 13'd0) + 13'(sec_r);
  assign dwi_calc = 21'(blk) * 21'(SECTOR_WORDS) + 21'(wd_r);

  always_comb begin
    cs_nxt    = cs_r;
    ds_nxt    = ds_r;
    er_nxt    = er_r;
    wc_nxt    = wc_r;
    ma_nxt    = ma_r;
    unit_nxt  = unit_r;
    cyl_nxt   = cyl_r;
    surf_nxt  = surf_r;
    sec_nxt   = sec_r;
    wd_nxt    = wd_r;
    rd_nxt    = 16'd0;
    xv_nxt    = 1'b0;
    tomem_nxt = 1'b0;
    ba_nxt    = 18'd0;
    du_nxt    = 3'd0;
    dwi_nxt   = 21'd0;
    irq_nxt   = 1'b0;
    do_adv    = 1'b0;
    do_finish = 1'b0;
    fn        = cs_r[3:1];
    cs_wr     = (cs_r & ~cdcr_pkg::CS_WRITABLE)
              | (wdata_r & cdcr_pkg::CS_WRITABLE & ~16'd1);

    unique case (act_r)
      cdcr_pkg::ACT_READ: begin
        unique case (idx_r)
          cdcr_pkg::REG_DS: rd_nxt = ds_r;
          cdcr_pkg::REG_ER: rd_nxt = er_r;
          cdcr_pkg::REG_CS: rd_nxt = cs_r | {10'd0, ma_r[17:16], 4'd0};
          cdcr_pkg::REG_WC: rd_nxt = wc_r;
          cdcr_pkg::REG_BA: rd_nxt = ma_r[15:0];
          cdcr_pkg::REG_DA: rd_nxt = {unit_r, cyl_r, surf_r, sec_r};
          default:          rd_nxt = 16'd0;
        endcase
      end
      cdcr_pkg::ACT_WRITE: begin
        unique case (idx_r)
          cdcr_pkg::REG_CS: begin
            ma_nxt = {wdata_r[5:4], ma_r[15:0]};
            cs_nxt = cs_wr;
            if (wdata_r[cdcr_pkg::CS_GO_BIT]) begin
              if (cs_wr[3:1] == cdcr_pkg::FN_CTRL_RESET) begin
                cs_nxt   = cdcr_pkg::CS_RESET;
                ds_nxt   = cdcr_pkg::DS_RESET;
                er_nxt   = 16'd0;
                wc_nxt   = 16'd0;
                ma_nxt   = 18'd0;
                unit_nxt = 3'd0;
                cyl_nxt  = 8'd0;
                surf_nxt = 1'b0;
                sec_nxt  = 4'd0;
                wd_nxt   = 9'd0;
              end else if (cs_wr[3:1] == cdcr_pkg::FN_WRITE ||
                           cs_wr[3:1] == cdcr_pkg::FN_READ) begin
                cs_nxt[cdcr_pkg::CS_READY_BIT] = 1'b0;
                ds_nxt[cdcr_pkg::DS_READY_BIT] = 1'b0;
                wd_nxt = 9'd0;
              end else begin
                irq_nxt = cs_wr[cdcr_pkg::CS_IE_BIT];
              end
            end
          end
          cdcr_pkg::REG_WC: wc_nxt = wdata_r;
          cdcr_pkg::REG_BA: ma_nxt = {ma_r[17:16], wdata_r};
          cdcr_pkg::REG_DA: begin
            unit_nxt = wdata_r[15:13];
            cyl_nxt  = wdata_r[12:5];
            surf_nxt = wdata_r[4];
            sec_nxt  = wdata_r[3:0];
          end
          default: ;
        endcase
      end
      cdcr_pkg::ACT_TICK: begin
        if (!cs_r[cdcr_pkg::CS_READY_BIT]) begin
          if (fn != cdcr_pkg::FN_WRITE && fn != cdcr_pkg::FN_READ) begin
            do_finish = 1'b1;
          end else begin
            if (wd_r == 9'd0) begin
              er_nxt = 16'd0;
              if (unit_r > 3'(DRIVE_COUNT - 1) || !mask_r[unit_r])
                er_nxt = er_nxt | cdcr_pkg::ER_NXD;
              if (cyl_r > 8'(LAST_CYLINDER))
                er_nxt = er_nxt | cdcr_pkg::ER_NXC;
              if (sec_r > cdcr_pkg::LAST_SECTOR)
                er_nxt = er_nxt | cdcr_pkg::ER_NXS;
            end
            if (wd_r == 9'd0 && er_nxt != 16'd0) begin
              do_finish = 1'b1;
            end else if (wc_r == 16'd0) begin
              do_adv    = 1'b1;
              do_finish = 1'b1;
            end else begin
              xv_nxt    = 1'b1;
              tomem_nxt = (fn == cdcr_pkg::FN_READ);
              ba_nxt    = ma_r;
              du_nxt    = unit_r;
              dwi_nxt   = dwi_calc;
              ma_nxt    = ma_r + 18'd2;
              wc_nxt    = wc_r + 16'd1;
              wd_nxt    = wd_r + 9'd1;
              if (wd_nxt >= 9'(SECTOR_WORDS) || wc_nxt == 16'd0)
                do_adv = 1'b1;
              if (wc_nxt == 16'd0)
                do_finish = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // past the last sector the sector returns to 0 and the surface toggles; after surface 1 the cylinder steps
    if (do_adv) begin
      wd_nxt = 9'd0;
      if (4'(sec_r + 4'd1) > cdcr_pkg::LAST_SECTOR) begin
        sec_nxt  = 4'd0;
        surf_nxt = ~surf_r;
        if (surf_r) begin
          cyl_nxt = cyl_r + 8'd1;
          if (cyl_nxt > 8'(LAST_CYLINDER))
            er_nxt = er_nxt | cdcr_pkg::ER_OVR;
        end
      end else begin
        sec_nxt = sec_r + 4'd1;
      end
    end

    if (do_finish) begin
      cs_nxt[cdcr_pkg::CS_READY_BIT] = 1'b1;
      ds_nxt[cdcr_pkg::DS_READY_BIT] = 1'b1;
      irq_nxt = cs_r[cdcr_pkg::CS_IE_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= cdcr_pkg::action_t'(in_action);
      idx_r   <= in_reg_index;
      wdata_r <= in_write_data;
    end
    if (cmd.execute) begin
      rd_r    <= rd_nxt;
      xv_r    <= xv_nxt;
      tomem_r <= tomem_nxt;
      ba_r    <= ba_nxt;
      du_r    <= du_nxt;
      dwi_r   <= dwi_nxt;
      irq_r   <= irq_nxt;
      rdy_r   <= cs_nxt[cdcr_pkg::CS_READY_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'd1;
      cs_r   <= cdcr_pkg::CS_RESET;
      ds_r   <= cdcr_pkg::DS_RESET;
      er_r   <= 16'd0;
      wc_r   <= 16'd0;
      ma_r   <= 18'd0;
      unit_r <= 3'd0;
      cyl_r  <= 8'd0;
      surf_r <= 1'b0;
      sec_r  <= 4'd0;
      wd_r   <= 9'd0;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      if (cmd.execute) begin
        cs_r   <= cs_nxt;
        ds_r   <= ds_nxt;
        er_r   <= er_nxt;
        wc_r   <= wc_nxt;
        ma_r   <= ma_nxt;
        unit_r <= unit_nxt;
        cyl_r  <= cyl_nxt;
        surf_r <= surf_nxt;
        sec_r  <= sec_nxt;
        wd_r   <= wd_nxt;
      end
    end
  end

  assign out_read_data         = rd_r;
  assign out_xfer_valid        = xv_r;
  assign out_xfer_to_memory    = tomem_r;
  assign out_bus_address       = ba_r;
  assign out_disk_unit         = du_r;
  assign out_disk_word_index   = dwi_r;
  assign out_interrupt_request = irq_r;
  assign out_controller_ready  = rdy_r;

endmodule

// ----- hw/rtl/cartridge_disk_controller_registers.sv -----
// ----------------------------------------------------------------------------
// cartridge_disk_controller_registers
// Cartridge disk controller register file with a DMA word sequencer.
// ----------------------------------------------------------------------------
// An item (register read, register write or transfer tick) is taken when
// start is high and busy is low. Each item has a capture cycle, then the
// execute state (busy high) in which the register file and sequencer
// update. The result appears on the out_ ports for exactly one cycle with
// out_valid high, the cycle after execute; the next item may be started in
// that same cycle, so a new item is not taken while one is executing. The
// receiver cannot stall: every result must be taken when out_valid is high.
// cfg_we writes the attached drive mask; write it only while the block is
// idle.
module cartridge_disk_controller_registers #(
  parameter int SECTOR_WORDS  = cdcr_pkg::SECTOR_WORDS_DEF,
  parameter int DRIVE_COUNT   = cdcr_pkg::DRIVE_COUNT_DEF,
  parameter int LAST_CYLINDER = cdcr_pkg::LAST_CYLINDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_reg_index,
  input  logic [15:0] in_write_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [15:0] out_read_data,
  output logic        out_xfer_valid,
  output logic        out_xfer_to_memory,
  output logic [17:0] out_bus_address,
  output logic [2:0]  out_disk_unit,
  output logic [20:0] out_disk_word_index,
  output logic        out_interrupt_request,
  output logic        out_controller_ready
);

  cdcr_pkg::cmd_t cmd;

  cdcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  cdcr_dp #(
    .SECTOR_WORDS  (SECTOR_WORDS),
    .DRIVE_COUNT   (DRIVE_COUNT),
    .LAST_CYLINDER (LAST_CYLINDER)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_action             (in_action),
    .in_reg_index          (in_reg_index),
    .in_write_data         (in_write_data),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_read_data         (out_read_data),
    .out_xfer_valid        (out_xfer_valid),
    .out_xfer_to_memory    (out_xfer_to_memory),
    .out_bus_address       (out_bus_address),
    .out_disk_unit         (out_disk_unit),
    .out_disk_word_index   (out_disk_word_index),
    .out_interrupt_request (out_interrupt_request),
    .out_controller_ready  (out_controller_ready)
  );

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_valid)
    else $error("accepted item did not produce a result");

  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_no_xfer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_xfer_valid) |->
      (out_bus_address == 18'd0 && out_disk_word_index == 21'd0 && !out_xfer_to_memory))
    else $error("transfer fields set without a transfer");

  a_xfer_not_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_xfer_valid) |-> (out_read_data == 16'd0))
    else $error("read data on a transfer tick");
`endif

endmodule
